/* rtl/core/flash_append_record_store_core_assert.svh */
// ----------------------------------------------------------------------------
// flash append record store - assertion macros
// shared concurrent assertion forms, clocked on i_clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef FLASH_APPEND_RECORD_STORE_CORE_ASSERT_SVH
`define FLASH_APPEND_RECORD_STORE_CORE_ASSERT_SVH

// condition holds at every edge
`define FARS_ASSERT_HOLDS(name, cond, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// consequent holds in the same cycle as the antecedent
`define FARS_ASSERT_IMPLIES(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define FARS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/fars_pkg.sv */
// ----------------------------------------------------------------------------
// fars_pkg
// types, constants and helpers shared by the append record store modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fars_pkg;

    localparam int STORE_WORDS = 2048;
    localparam int AW          = $clog2(STORE_WORDS);
    localparam int PW          = AW + 1;
    localparam int RD_W        = 17;

    localparam int KIND_W  = 2;
    localparam int LEN_W   = 12;
    localparam int WORD_W  = 16;
    localparam int IDX_W   = 11;
    localparam int STAT_W  = 3;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    localparam logic [WORD_W-1:0] ERASED = 16'hFFFF;

    typedef enum logic [KIND_W-1:0] {
        KIND_OPEN = 2'd0,
        KIND_DATA = 2'd1,
        KIND_READ = 2'd2
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_OK_ERASED = 3'd1,
        ST_NO_RECORD = 3'd2,
        ST_BAD_LENGTH = 3'd3,
        ST_RANGE     = 3'd4,
        ST_NOT_OPEN  = 3'd5,
        ST_TOO_LONG  = 3'd6
    } t_status;

    typedef struct packed {
        t_status            status;
        logic [WORD_W-1:0]  read_word;
        logic [LEN_W-1:0]   found_bytes;
        logic [LEN_W-1:0]   start_offset;
        logic               record_done;
    } t_res;

    typedef struct packed {
        logic               wr_en;
        logic [AW-1:0]      wr_addr;
        logic [WORD_W-1:0]  wr_data;
        logic               rd_en;
        logic [AW-1:0]      rd_addr;
    } t_ram_req;

    // byte offset of a halfword index, low 12 bits
    function automatic logic [LEN_W-1:0] off12(input logic [RD_W-1:0] p);
        return {p[LEN_W-2:0], 1'b0};
    endfunction

endpackage

/* rtl/core/fars_ram.sv */
// ----------------------------------------------------------------------------
// fars_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fars_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= mem[i_rd_addr];
        end
    end

endmodule

/* rtl/core/fars_ctrl.sv */
// ----------------------------------------------------------------------------
// fars_ctrl
// log pointers and item sequencer: turns each transaction into ram accesses
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "flash_append_record_store_core_assert.svh"

module fars_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [fars_pkg::KIND_W-1:0] i_kind,
    input  logic [fars_pkg::LEN_W-1:0]  i_record_bytes,
    input  logic [fars_pkg::WORD_W-1:0] i_data_word,
    input  logic [fars_pkg::IDX_W-1:0]  i_read_index,
    output fars_pkg::t_ram_req          o_ram,
    input  logic [fars_pkg::WORD_W-1:0] i_rd_data,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output fars_pkg::t_res              o_res
);

    import fars_pkg::*;

    localparam int CW = (PW + 1 > 14) ? PW + 1 : 14;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LEN,
        S_RD,
        S_EMIT
    } t_state;

    t_state             r_state, n_state;
    logic [PW-1:0]      r_wp, n_wp;
    logic [PW-1:0]      r_end, n_end;
    logic [WORD_W-1:0]  r_last, n_last;
    logic [AW-1:0]      r_left, n_left;
    logic [LEN_W-1:0]   r_open_len, n_open_len;
    logic               r_open, n_open;
    logic [PW-1:0]      r_rec_start, n_rec_start;
    t_res               r_res, n_res;

    logic [CW-1:0]      w_dwords;
    logic               w_too_long;
    logic               w_erase;
    logic [PW-1:0]      w_pos;
    logic [RD_W-1:0]    w_li;
    logic [RD_W-1:0]    w_rd_dw;
    logic [RD_W-1:0]    w_sw;
    logic [RD_W-1:0]    w_rd_idx;
    logic               w_wr;
    logic [PW-1:0]      w_wr_idx;
    logic [WORD_W-1:0]  w_wr_data;

    // open: data halfwords needed and whether they fit above the log end
    always_comb begin
        w_dwords   = (CW'(i_record_bytes) + CW'(1)) >> 1;
        w_too_long = (w_dwords + CW'(1)) > CW'(STORE_WORDS);
        w_erase    = (CW'(STORE_WORDS) - CW'(r_end)) < (w_dwords + CW'(1));
        w_pos      = w_erase ? '0 : r_end;
    end

    // read: newest record sits below the length halfword at the log end
    always_comb begin
        w_li     = RD_W'(r_end) - RD_W'(1);
        w_rd_dw  = (RD_W'(r_last) + RD_W'(1)) >> 1;
        w_sw     = w_li - w_rd_dw;
        w_rd_idx = w_sw + RD_W'(i_read_index);
    end

    always_comb begin
        n_state     = r_state;
        n_wp        = r_wp;
        n_end       = r_end;
        n_last      = r_last;
        n_left      = r_left;
        n_open_len  = r_open_len;
        n_open      = r_open;
        n_rec_start = r_rec_start;
        n_res       = r_res;
        w_wr        = 1'b0;
        w_wr_idx    = r_wp;
        w_wr_data   = i_data_word;
        o_ram       = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_res        = '0;
                    n_res.status = ST_RANGE;
                    n_state      = S_EMIT;
                    unique case (i_kind)
                        KIND_OPEN: begin
                            if (w_too_long) begin
                                n_res.status = ST_TOO_LONG;
                            end else begin
                                n_res.status       = w_erase ? ST_OK_ERASED : ST_OK;
                                n_res.found_bytes  = i_record_bytes;
                                n_res.start_offset = off12(RD_W'(w_pos));
                                n_rec_start        = w_pos;
                                n_open_len         = i_record_bytes;
                                n_left             = AW'(w_dwords);
                                n_end              = w_pos;
                                n_wp               = w_pos;
                                if (w_dwords == '0) begin
                                    // empty record: length halfword straight away
                                    w_wr              = 1'b1;
                                    w_wr_idx          = w_pos;
                                    w_wr_data         = WORD_W'(i_record_bytes);
                                    n_wp              = w_pos + PW'(1);
                                    n_end             = w_pos + PW'(1);
                                    n_last            = WORD_W'(i_record_bytes);
                                    n_open            = 1'b0;
                                    n_res.record_done = 1'b1;
                                end else begin
                                    n_open = 1'b1;
                                end
                            end
                        end
                        KIND_DATA: begin
                            if (!r_open) begin
                                n_res.status = ST_NOT_OPEN;
                            end else begin
                                w_wr               = 1'b1;
                                w_wr_idx           = r_wp;
                                w_wr_data          = i_data_word;
                                n_wp               = r_wp + PW'(1);
                                n_left             = r_left - AW'(1);
                                // erased-value data leaves the log end where it was
                                if (i_data_word != ERASED) begin
                                    n_end  = r_wp + PW'(1);
                                    n_last = i_data_word;
                                end
                                n_res.status       = ST_OK;
                                n_res.found_bytes  = r_open_len;
                                n_res.start_offset = off12(RD_W'(r_rec_start));
                                if (r_left == AW'(1)) begin
                                    n_open            = 1'b0;
                                    n_res.record_done = 1'b1;
                                    n_state           = S_LEN;
                                end
                            end
                        end
                        KIND_READ: begin
                            if (r_end == '0) begin
                                n_res.status = ST_NO_RECORD;
                            end else if (w_rd_dw > w_li) begin
                                n_res.status = ST_BAD_LENGTH;
                            end else begin
                                n_res.found_bytes  = r_last[LEN_W-1:0];
                                n_res.start_offset = off12(w_sw);
                                if (RD_W'(i_read_index) >= w_rd_dw) begin
                                    n_res.status = ST_RANGE;
                                end else begin
                                    n_res.status  = ST_OK;
                                    o_ram.rd_en   = 1'b1;
                                    o_ram.rd_addr = w_rd_idx[AW-1:0];
                                    n_state       = S_RD;
                                end
                            end
                        end
                        default: begin
                            n_res.status = ST_RANGE;
                        end
                    endcase
                end
            end
            S_LEN: begin
                w_wr      = 1'b1;
                w_wr_idx  = r_wp;
                w_wr_data = WORD_W'(r_open_len);
                n_wp      = r_wp + PW'(1);
                n_end     = r_wp + PW'(1);
                n_last    = WORD_W'(r_open_len);
                n_state   = S_EMIT;
            end
            S_RD: begin
                n_res.read_word = i_rd_data;
                n_state         = S_EMIT;
            end
            S_EMIT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        o_ram.wr_en   = w_wr && (w_wr_idx < PW'(STORE_WORDS));
        o_ram.wr_addr = w_wr_idx[AW-1:0];
        o_ram.wr_data = w_wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= '0;
            r_end       <= '0;
            r_last      <= '0;
            r_left      <= '0;
            r_open_len  <= '0;
            r_open      <= 1'b0;
            r_rec_start <= '0;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_end       <= n_end;
            r_last      <= n_last;
            r_left      <= n_left;
            r_open_len  <= n_open_len;
            r_open      <= n_open;
            r_rec_start <= n_rec_start;
            r_res       <= n_res;
        end
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_EMIT);
    assign o_res       = r_res;

    // nothing at or above the write pointer can hold the log end
    `FARS_ASSERT_HOLDS(a_end_le_wp, r_end <= r_wp, "log end beyond write pointer")
    `FARS_ASSERT_IMPLIES(a_open_left, r_open, r_left != '0, "open record with no words left")
    `FARS_ASSERT_IMPLIES(a_wr_range, w_wr, w_wr_idx < PW'(STORE_WORDS), "write past store end")
    `FARS_ASSERT_IMPLIES(a_no_rw, o_ram.rd_en, !o_ram.wr_en, "read and write in one cycle")
    `FARS_ASSERT_NEXT(a_len_done, r_state == S_LEN, r_state == S_EMIT && r_res.record_done, "length write lost")

endmodule

/* rtl/core/fars_out.sv */
// ----------------------------------------------------------------------------
// fars_out
// output register stage, frees the sequencer while a result waits downstream
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fars_out (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  fars_pkg::t_res i_res,
    output logic           o_valid,
    input  logic           i_ready,
    output fars_pkg::t_res o_res
);

    import fars_pkg::*;

    logic r_valid;
    t_res r_res;

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

/* rtl/core/flash_append_record_store_core.sv */
// ----------------------------------------------------------------------------
// flash_append_record_store_core
// append log of records in an erasable halfword store, streaming front end
// ----------------------------------------------------------------------------
// Items are taken one at a time. An open, a failed read and a data halfword
// go straight to the result state; a successful read first waits for the
// registered read data of the store ram, and the halfword that closes a
// record first lets the single ram write port take the length halfword. The
// log end and the value at it are kept in registers, so an open or read needs
// no scan and an erase of the whole store completes at once: nothing above
// the log end is ever read back. After reset the block is ready immediately.
`timescale 1ns / 1ps

module flash_append_record_store_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // record_bytes[11:0], data_word[27:12], read_index[38:28], zero [39]
    input  logic [fars_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // kind[1:0]
    input  logic [fars_pkg::KIND_W-1:0]     s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // read_word[15:0], found_bytes[27:16], start_offset[39:28]
    output logic [fars_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // status[2:0]
    output logic [fars_pkg::STAT_W-1:0]     m_axis_tuser,
    // record_done
    output logic                            m_axis_tlast
);

    import fars_pkg::*;

    t_ram_req          ram_req;
    logic [WORD_W-1:0] rd_data;
    logic              res_valid;
    logic              res_ready;
    t_res              res;
    t_res              out_res;

    fars_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_kind         (s_axis_tuser),
        .i_record_bytes (s_axis_tdata[11:0]),
        .i_data_word    (s_axis_tdata[27:12]),
        .i_read_index   (s_axis_tdata[38:28]),
        .o_ram          (ram_req),
        .i_rd_data      (rd_data),
        .o_res_valid    (res_valid),
        .i_res_ready    (res_ready),
        .o_res          (res)
    );

    fars_ram #(
        .DEPTH (STORE_WORDS),
        .WIDTH (WORD_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_req.wr_en),
        .i_wr_addr (ram_req.wr_addr),
        .i_wr_data (ram_req.wr_data),
        .i_rd_en   (ram_req.rd_en),
        .i_rd_addr (ram_req.rd_addr),
        .o_rd_data (rd_data)
    );

    fars_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .o_ready (res_ready),
        .i_res   (res),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (out_res)
    );

    assign m_axis_tdata = {out_res.start_offset, out_res.found_bytes, out_res.read_word};
    assign m_axis_tuser = out_res.status;
    assign m_axis_tlast = out_res.record_done;

endmodule

/* tb/tb_flash_append_record_store_core.sv */
// ----------------------------------------------------------------------------
// tb_flash_append_record_store_core
// drives opens, data halfwords and reads into the append log store and checks
// every result against a running software image of the store and its pointers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_flash_append_record_store_core;

    import fars_pkg::*;

    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 300000;
    localparam int TAIL_CYCLES = 20;

    // image of the store plus the open-record bookkeeping
    class record_log_scoreboard;
        logic [WORD_W-1:0] mem [STORE_WORDS];
        int unsigned       wr_ptr;
        int unsigned       words_left;
        int unsigned       rec_start;
        logic [LEN_W-1:0]  open_len;
        bit                rec_open;
        t_res              expected_q [$];
        int                errors;
        int                checked;
        int                status_seen [8];
        int                closed_records;

        function new();
            foreach (mem[i]) mem[i] = ERASED;
            wr_ptr     = 0;
            words_left = 0;
            rec_start  = 0;
            open_len   = '0;
            rec_open   = 1'b0;
            errors     = 0;
            checked    = 0;
            closed_records = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        // one past the highest halfword that is not erased
        function int unsigned log_end();
            for (int k = STORE_WORDS; k > 0; k--)
                if (mem[k-1] !== ERASED) return k;
            return 0;
        endfunction

        function void put_word(int unsigned idx, logic [WORD_W-1:0] v);
            if (idx < STORE_WORDS) mem[idx] = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_input(logic [KIND_W-1:0] kind, logic [LEN_W-1:0] len,
                                 logic [WORD_W-1:0] dw, logic [IDX_W-1:0] ridx);
            t_res        r;
            int unsigned pos;
            int unsigned dwords;
            int unsigned li;
            int unsigned flen;
            int unsigned sw;
            r = '0;
            r.status = ST_RANGE;
            case (kind)
                KIND_OPEN: begin
                    dwords = (len + 1) / 2;
                    if (dwords + 1 > STORE_WORDS) begin
                        r.status = ST_TOO_LONG;
                    end else begin
                        pos = log_end();
                        r.status = ST_OK;
                        if (STORE_WORDS - pos < dwords + 1) begin
                            foreach (mem[i]) mem[i] = ERASED;
                            pos = 0;
                            r.status = ST_OK_ERASED;
                        end
                        rec_start  = pos;
                        open_len   = len;
                        words_left = dwords;
                        wr_ptr     = pos;
                        r.found_bytes  = len;
                        r.start_offset = 12'(pos * 2);
                        if (dwords == 0) begin
                            put_word(wr_ptr, 16'(len));
                            wr_ptr++;
                            rec_open = 1'b0;
                            r.record_done = 1'b1;
                        end else begin
                            rec_open = 1'b1;
                        end
                    end
                end
                KIND_DATA: begin
                    if (!rec_open) begin
                        r.status = ST_NOT_OPEN;
                    end else begin
                        put_word(wr_ptr, dw);
                        wr_ptr++;
                        words_left--;
                        // last data halfword also lays down the length halfword
                        if (words_left == 0) begin
                            put_word(wr_ptr, 16'(open_len));
                            wr_ptr++;
                            rec_open = 1'b0;
                            r.record_done = 1'b1;
                        end
                        r.status       = ST_OK;
                        r.found_bytes  = open_len;
                        r.start_offset = 12'(rec_start * 2);
                    end
                end
                KIND_READ: begin
                    pos = log_end();
                    if (pos == 0) begin
                        r.status = ST_NO_RECORD;
                    end else begin
                        li     = pos - 1;
                        flen   = mem[li];
                        dwords = (flen + 1) / 2;
                        if (dwords > li) begin
                            r.status = ST_BAD_LENGTH;
                        end else begin
                            sw = li - dwords;
                            r.found_bytes  = 12'(flen);
                            r.start_offset = 12'(sw * 2);
                            if (ridx >= dwords) begin
                                r.status = ST_RANGE;
                            end else begin
                                r.status    = ST_OK;
                                r.read_word = mem[sw + ridx];
                            end
                        end
                    end
                end
                default: begin
                    // spare kind leaves everything alone
                end
            endcase
            expected_q.push_back(r);
        endfunction

        function void compare(string what, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            end
        endfunction

        function void check_result(t_res got);
            t_res want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result transaction, expected none, actual %h",
                         $time, got);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            status_seen[want.status]++;
            closed_records += want.record_done;
            compare("status", 16'(want.status), 16'(got.status));
            compare("read_word", want.read_word, got.read_word);
            compare("found_bytes", 16'(want.found_bytes), 16'(got.found_bytes));
            compare("start_offset", 16'(want.start_offset), 16'(got.start_offset));
            compare("record_done", 16'(want.record_done), 16'(got.record_done));
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
    logic [KIND_W-1:0]       s_axis_tuser = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic [STAT_W-1:0]       m_axis_tuser;
    logic                    m_axis_tlast;

    record_log_scoreboard sb = new();
    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int sent = 0;
    int cycles = 0;

    flash_append_record_store_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, sb.pending());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side: check on handshake, then pick next ready
    always @(posedge i_clk) begin : rx
        t_res got;
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            got.status       = t_status'(m_axis_tuser);
            got.read_word    = m_axis_tdata[15:0];
            got.found_bytes  = m_axis_tdata[27:16];
            got.start_offset = m_axis_tdata[39:28];
            got.record_done  = m_axis_tlast;
            sb.check_result(got);
        end
        m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return ERASED;
            default: return WORD_W'($urandom);
        endcase
    endfunction

    // valid is only dropped when a gap is taken, so it is never lowered and
    // raised in one step
    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [LEN_W-1:0] len,
                             input logic [WORD_W-1:0] dw, input logic [IDX_W-1:0] ridx);
        if ($urandom_range(0, 99) < snd_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < snd_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, ridx, dw, len};
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_input(kind, len, dw, ridx);
        sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic run_directed();
        send_item(KIND_READ, 12'd0, 16'h0000, 11'd0);      // empty store
        send_item(KIND_DATA, 12'd0, 16'h1234, 11'd0);      // nothing open
        send_item(KIND_SPARE, 12'hFFF, 16'hFFFF, 11'h7FF);
        send_item(KIND_OPEN, 12'hFFF, 16'h0000, 11'd0);    // can never fit
        // a lone zero halfword at the bottom still marks the log end
        send_item(KIND_OPEN, 12'd4, 16'h0000, 11'd0);
        send_item(KIND_DATA, 12'd0, 16'h0000, 11'd0);
        send_item(KIND_READ, 12'd0, 16'h0000, 11'd0);
        send_item(KIND_READ, 12'd0, 16'h0000, 11'h7FF);
        // abandon it; odd length record with padding in its last halfword
        send_item(KIND_OPEN, 12'd3, 16'h0000, 11'd0);
        send_item(KIND_DATA, 12'd0, 16'hA5C3, 11'd0);
        send_item(KIND_DATA, 12'd0, 16'h00FF, 11'd0);
        send_item(KIND_READ, 12'd0, 16'h0000, 11'd0);
        send_item(KIND_READ, 12'd0, 16'h0000, 11'd1);
        send_item(KIND_READ, 12'd0, 16'h0000, 11'd2);
        send_item(KIND_OPEN, 12'd0, 16'h0000, 11'd0);      // empty record
        send_item(KIND_READ, 12'd0, 16'h0000, 11'd0);
        // a half-written record whose top halfword looks like a huge length
        send_item(KIND_OPEN, 12'd6, 16'h0000, 11'd0);
        send_item(KIND_DATA, 12'd0, 16'h0001, 11'd0);
        send_item(KIND_DATA, 12'd0, 16'hFFFE, 11'd0);
        send_item(KIND_READ, 12'd0, 16'h0000, 11'd0);
        send_item(KIND_DATA, 12'd0, 16'hFFFF, 11'd0);
        send_item(KIND_READ, 12'd0, 16'h0000, 11'd2);
        send_item(KIND_OPEN, 12'd4094, 16'h0000, 11'd0);   // forces erase
        send_item(KIND_OPEN, 12'd2, 16'h0000, 11'd0);
        send_item(KIND_DATA, 12'd0, 16'hFFFF, 11'd0);
        send_item(KIND_READ, 12'd0, 16'h0000, 11'd0);
    endtask

    task automatic run_random(input int n_items);
        int stop_at;
        int pick;
        int rlen;
        int nwords;
        int nreads;
        stop_at = sent + n_items;
        while (sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                // complete record, then a few reads of it
                rlen = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 400)
                                                    : $urandom_range(0, 40);
                nwords = (rlen + 1) / 2;
                send_item(KIND_OPEN, LEN_W'(rlen), rand_word(), IDX_W'($urandom));
                for (int k = 0; k < nwords; k++)
                    send_item(KIND_DATA, LEN_W'($urandom), rand_word(), IDX_W'($urandom));
                nreads = $urandom_range(0, 3);
                for (int k = 0; k < nreads; k++)
                    send_item(KIND_READ, LEN_W'($urandom), rand_word(),
                              ($urandom_range(0, 3) == 0) ? IDX_W'($urandom)
                                                          : IDX_W'($urandom_range(0, nwords + 1)));
            end else if (pick < 70) begin
                // open of any size, cut short: erases, abandons, too-long
                send_item(KIND_OPEN, LEN_W'($urandom), rand_word(), IDX_W'($urandom));
                nwords = $urandom_range(0, 3);
                for (int k = 0; k < nwords; k++)
                    send_item(KIND_DATA, LEN_W'($urandom), rand_word(), IDX_W'($urandom));
            end else if (pick < 82) begin
                send_item(KIND_READ, LEN_W'($urandom), rand_word(),
                          IDX_W'($urandom_range(0, 24)));
            end else begin
                send_item(KIND_W'($urandom), LEN_W'($urandom), rand_word(), IDX_W'($urandom));
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        snd_idle_pct = 38;
        rcv_idle_pct = 80;
        run_directed();
        run_random(200);
        drain();

        snd_idle_pct = 80;
        rcv_idle_pct = 38;
        run_random(200);
        drain();

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        run_random(200);
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d transactions in, %0d results checked, %0d records closed",
                 sent, sb.checked, sb.closed_records);
        $write("ok %0d, ok after erase %0d, no record %0d, bad length %0d, range %0d, ",
               sb.status_seen[ST_OK], sb.status_seen[ST_OK_ERASED],
               sb.status_seen[ST_NO_RECORD], sb.status_seen[ST_BAD_LENGTH],
               sb.status_seen[ST_RANGE]);
        $display("not open %0d, too long %0d",
                 sb.status_seen[ST_NOT_OPEN], sb.status_seen[ST_TOO_LONG]);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* flash_append_record_store_core.f */
+incdir+rtl/core
rtl/core/fars_pkg.sv
rtl/core/fars_ram.sv
rtl/core/fars_ctrl.sv
rtl/core/fars_out.sv
rtl/core/flash_append_record_store_core.sv
tb/tb_flash_append_record_store_core.sv
